// ===== rtl/assert_macros.svh =====
// Shared concurrent assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/setq_pkg.sv =====
`timescale 1ns / 1ps

package setq_pkg;

    localparam int TIME_W          = 64;
    localparam int SYN_W           = 10;
    localparam int DEF_QUEUE_DEPTH = 64;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_FLUSH  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [TIME_W-1:0] spike_time;
        logic [SYN_W-1:0]  syn_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [TIME_W-1:0] out_time;
        logic [SYN_W-1:0]  out_syn_index;
    } rsp_t;

    // One stored event.
    typedef struct packed {
        logic              occupied;
        logic [TIME_W-1:0] evt_time;
        logic [SYN_W-1:0]  syn;
    } entry_t;

    // Operation broadcast to every cell.
    typedef struct packed {
        logic              ins;
        logic              pop;
        logic              flush;
        logic [TIME_W-1:0] evt_time;
        logic [SYN_W-1:0]  syn;
    } cell_op_t;

endpackage

// ===== rtl/setq_cell.sv =====
`timescale 1ns / 1ps

module setq_cell
    import setq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cell_op_t op,
    input  entry_t   prev_entry,
    input  logic     prev_gt,
    input  entry_t   next_entry,
    output entry_t   cur_entry,
    output logic     gt
);

    logic              occ_reg;
    logic [TIME_W-1:0] time_reg;
    logic [SYN_W-1:0]  syn_reg;
    entry_t            cur_next;

    assign cur_entry = {occ_reg, time_reg, syn_reg};

    // Slot is at or past the insert point: empty, or holds a strictly later time.
    assign gt = !occ_reg || (op.evt_time < time_reg);

    always_comb
    begin
        cur_next = cur_entry;
        if (op.flush)
        begin
            cur_next.occupied = 1'b0;
        end
        else if (op.pop)
        begin
            cur_next = next_entry;
        end
        else if (op.ins && gt)
        begin
            if (prev_gt)
            begin
                cur_next = prev_entry;
            end
            else
            begin
                cur_next.occupied = 1'b1;
                cur_next.evt_time = op.evt_time;
                cur_next.syn      = op.syn;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= cur_next.occupied;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= cur_next.evt_time;
        syn_reg  <= cur_next.syn;
    end

endmodule

// ===== rtl/setq_skid.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module setq_skid
    import setq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rsp_t push_word,
    output logic full,
    output logic valid,
    input  logic stall,
    output rsp_t word
);

    rsp_t head_reg;
    rsp_t head_next;
    rsp_t tail_reg;
    rsp_t tail_next;
    logic head_vld_reg;
    logic head_vld_next;
    logic tail_vld_reg;
    logic tail_vld_next;
    logic pop;

    assign pop = head_vld_reg && !stall;

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        head_vld_next = head_vld_reg;
        tail_vld_next = tail_vld_reg;
        if (pop)
        begin
            head_next     = tail_reg;
            head_vld_next = tail_vld_reg;
            tail_vld_next = 1'b0;
            if (push)
            begin
                if (tail_vld_reg)
                begin
                    tail_next     = push_word;
                    tail_vld_next = 1'b1;
                end
                else
                begin
                    head_next     = push_word;
                    head_vld_next = 1'b1;
                end
            end
        end
        else if (push)
        begin
            if (!head_vld_reg)
            begin
                head_next     = push_word;
                head_vld_next = 1'b1;
            end
            else
            begin
                tail_next     = push_word;
                tail_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
            tail_vld_reg <= 1'b0;
        end
        else
        begin
            head_vld_reg <= head_vld_next;
            tail_vld_reg <= tail_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign full  = tail_vld_reg;
    assign valid = head_vld_reg;
    assign word  = head_reg;

    `ASSERT_NOW(a_skid_order, clk, rst_n, tail_vld_reg, head_vld_reg, "skid word without head word")

endmodule

// ===== rtl/sorted_event_time_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  Dir  Handshake            Word
// cmd      in   cmd_valid/cmd_stall  cmd_t: action, spike_time, syn_index
// rsp      out  rsp_valid/rsp_stall  rsp_t: status, out_time, out_syn_index
//
// One command word per cycle while cmd_stall is low; the chain of cells updates in the
// accepting cycle. Response word shows on rsp the cycle after accept if no older one is
// left unread; a two-word output buffer keeps accepting while one response waits.
// cmd_stall rises only when two responses sit unread (registered, no path from rsp_stall).
// Reset (rst_n low, async) empties the queue and the output buffer.

module sorted_event_time_queue
    import setq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // Chain of QUEUE_DEPTH-1 cells holds at most QUEUE_DEPTH-1 events.
    localparam int CELLS = QUEUE_DEPTH - 1;

    entry_t           cell_state [CELLS];
    logic [CELLS-1:0] cell_gt;
    logic [CELLS-1:0] occ_vec;
    logic [CELLS:0]   occ_plus;
    cell_op_t         op;
    rsp_t             rsp_new;
    logic             accept;
    logic             q_full;
    logic             q_empty;
    logic             buf_full;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = buf_full;

    // Cell 0 holds the earliest event; occupied cells form a prefix.
    assign q_empty = !cell_state[0].occupied;
    assign q_full  = cell_state[CELLS-1].occupied;

    assign op.ins      = accept && (cmd.action == ACT_INSERT) && !q_full;
    assign op.pop      = accept && (cmd.action == ACT_POP) && !q_empty;
    assign op.flush    = accept && (cmd.action == ACT_FLUSH);
    assign op.evt_time = cmd.spike_time;
    assign op.syn      = cmd.syn_index;

    // Response, built in the accepting cycle from the pre-update chain.
    always_comb
    begin
        rsp_new.status        = STATUS_OK;
        rsp_new.out_time      = '0;
        rsp_new.out_syn_index = '0;
        case (cmd.action)
            ACT_INSERT:
            begin
                if (q_full)
                begin
                    rsp_new.status = STATUS_FULL;
                end
            end
            ACT_POP:
            begin
                if (q_empty)
                begin
                    rsp_new.status = STATUS_EMPTY;
                end
                else
                begin
                    rsp_new.out_time      = cell_state[0].evt_time;
                    rsp_new.out_syn_index = cell_state[0].syn;
                end
            end
            default:
            begin
                rsp_new.status = STATUS_OK;
            end
        endcase
    end

    // Chain: insert shifts later entries up one cell, pop shifts all down one, flush empties all.
    genvar i;
    generate
        for (i = 0; i < CELLS; i++)
        begin : g_cell
            entry_t prev_e;
            entry_t next_e;
            logic   prev_g;

            if (i == 0)
            begin : g_first
                assign prev_e = '0;
                assign prev_g = 1'b0;
            end
            else
            begin : g_mid
                assign prev_e = cell_state[i-1];
                assign prev_g = cell_gt[i-1];
            end

            if (i == CELLS - 1)
            begin : g_last
                assign next_e = '0;
            end
            else
            begin : g_inner
                assign next_e = cell_state[i+1];
            end

            setq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .prev_entry (prev_e),
                .prev_gt    (prev_g),
                .next_entry (next_e),
                .cur_entry  (cell_state[i]),
                .gt         (cell_gt[i])
            );

            assign occ_vec[i] = cell_state[i].occupied;
        end
    endgenerate

    setq_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (rsp_new),
        .full      (buf_full),
        .valid     (rsp_valid),
        .stall     (rsp_stall),
        .word      (rsp)
    );

    assign occ_plus = {1'b0, occ_vec} + {{CELLS{1'b0}}, 1'b1};

    `ASSERT_NOW(a_occ_prefix, clk, rst_n, 1'b1, $onehot(occ_plus), "occupied cells not a prefix")
    `ASSERT_NEXT(a_flush_empty, clk, rst_n, op.flush, !cell_state[0].occupied, "flush left events")
    `ASSERT_NEXT(a_insert_fill, clk, rst_n, op.ins, cell_state[0].occupied, "insert left queue empty")
    `ASSERT_NEXT(a_rsp_ready, clk, rst_n, accept, rsp_valid, "accepted command gave no response")

endmodule

// ===== sim/setq_checker.sv =====
`timescale 1ns / 1ps

module setq_checker
    import setq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_stall,
    input  cmd_t cmd,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);

    logic [TIME_W-1:0] slot_time [QUEUE_DEPTH];
    logic [SYN_W-1:0]  slot_syn  [QUEUE_DEPTH];
    int                head;    // earliest event
    int                tail;    // next free slot
    rsp_t              answers_due[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        head        = 0;
        tail        = 0;
    end

    function automatic int ring_next(int p);
        return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
    endfunction

    function automatic int ring_prev(int p);
        return (p == 0) ? QUEUE_DEPTH - 1 : p - 1;
    endfunction

    // Apply one command to the ring and return the response word it must produce.
    function automatic rsp_t sorted_queue_answer(cmd_t c);
        rsp_t r;
        int   slot;
        int   below;
        r        = '0;
        r.status = STATUS_OK;
        case (c.action)
            ACT_INSERT:
            begin
                if (ring_next(tail) == head)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    // shift later stamps up; equal stamps stay ahead of the new one
                    slot = tail;
                    while (slot != head)
                    begin
                        below = ring_prev(slot);
                        if (c.spike_time < slot_time[below])
                        begin
                            slot_time[slot] = slot_time[below];
                            slot_syn[slot]  = slot_syn[below];
                            slot            = below;
                        end
                        else
                        begin
                            break;
                        end
                    end
                    slot_time[slot] = c.spike_time;
                    slot_syn[slot]  = c.syn_index;
                    tail            = ring_next(tail);
                end
            end
            ACT_POP:
            begin
                if (head == tail)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    r.out_time      = slot_time[head];
                    r.out_syn_index = slot_syn[head];
                    head            = ring_next(head);
                end
            end
            ACT_FLUSH:
            begin
                head = tail;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            answers_due.delete();
            head = 0;
            tail = 0;
        end
        else
        begin
            // response first: a word accepted now belongs to an older command
            if (rsp_valid && !rsp_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("unexpected response word: status %0d time %0h syn %0h",
                           rsp.status, rsp.out_time, rsp.out_syn_index);
                    mismatches++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.out_time !== want.out_time)
                    begin
                        $error("out_time: expected %0h, got %0h", want.out_time, rsp.out_time);
                        mismatches++;
                    end
                    if (rsp.out_syn_index !== want.out_syn_index)
                    begin
                        $error("out_syn_index: expected %0h, got %0h",
                               want.out_syn_index, rsp.out_syn_index);
                        mismatches++;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                answers_due.push_back(sorted_queue_answer(cmd));
            end
        end
        outstanding = answers_due.size();
    end

endmodule

// ===== sim/tb_sorted_event_time_queue.sv =====
`timescale 1ns / 1ps

module tb_sorted_event_time_queue
    import setq_pkg::*;
();

    // Action code 3 is not decoded by the block: no change, status ok.
    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         RANDOM_WORDS   = 1430;
    localparam int         HOLD_CYCLES    = 200;
    localparam int         WATCHDOG_LIMIT = 4000;

    // Random burst flavors: fill pushes toward full, drain toward empty.
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int   mismatches;
    int   outstanding;
    int   quiet_cycles = 0;

    // Shared between stimulus and receiver processes.
    bit   idle_en  = 1'b1;   // random idling on both sides
    bit   hold_req = 1'b0;   // ask the receiver for one long hold-off

    logic [TIME_W-1:0] stamp_base = '0;

    always #2 clk = ~clk;

    sorted_event_time_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    setq_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Offer one command word. Any idle gap comes first, with valid low; once
    // valid is up it stays up with a steady payload until the word is taken.
    // Returns at the falling edge after the accepting rising edge, so the next
    // call can keep valid high back to back.
    task automatic send_word(input logic [1:0] act, input logic [TIME_W-1:0] stamp,
                             input logic [SYN_W-1:0] syn);
        while (idle_en && $urandom_range(0, 99) < 24)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd.action     <= act;
        cmd.spike_time <= stamp;
        cmd.syn_index  <= syn;
        cmd_valid      <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Timestamp mix: extremes, full-width random, a tiny range that forces ties,
    // and a slowly rising base so later inserts mostly land near the tail.
    function automatic logic [TIME_W-1:0] pick_stamp();
        logic [TIME_W-1:0] t;
        case ($urandom_range(0, 9))
            0:       t = '0;
            1:       t = '1;
            2, 3, 4: t = {$urandom, $urandom};
            5, 6:    t = TIME_W'($urandom_range(0, 15));
            default:
            begin
                stamp_base = stamp_base + TIME_W'($urandom_range(0, 3));
                t          = stamp_base + TIME_W'($urandom_range(0, 20));
            end
        endcase
        return t;
    endfunction

    // Receiver: random stalls, except for one long hold-off on request, which
    // backs the block up until it stalls the command side.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                rsp_stall <= idle_en && ($urandom_range(0, 99) < 24);
            end
        end
    end

    // Watchdog: too long without any word moving on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_sorted_event_time_queue: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int         sent;
        int         mode;
        int         burst_len;
        int         roll;
        int         ins_pct;
        logic [1:0] act;

        sent = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----
        send_word(ACT_POP, '0, '0);              // pop on empty queue
        send_word(ACT_UNUSED, '0, '0);           // unused code on empty queue
        send_word(ACT_INSERT, '1, '1);           // largest stamp, largest index
        send_word(ACT_INSERT, '0, '0);           // walk runs all the way to the head
        send_word(ACT_INSERT, 64'd5, 10'd1);     // two equal stamps: arrival order kept
        send_word(ACT_INSERT, 64'd5, 10'd2);
        send_word(ACT_INSERT, '1, 10'd5);        // ties with the largest, goes after it
        send_word(ACT_UNUSED, '1, '1);           // unused code with busy payload
        repeat (5) send_word(ACT_POP, '1, '1);   // drain in order, payload ignored
        send_word(ACT_POP, '0, '0);              // empty again
        send_word(ACT_INSERT, 64'h8000_0000_0000_0000, 10'h200);
        send_word(ACT_INSERT, 64'h7fff_ffff_ffff_ffff, 10'h1ff);
        send_word(ACT_INSERT, 64'h0000_0000_ffff_ffff, 10'h155);
        send_word(ACT_FLUSH, '1, '1);            // flush drops all three
        send_word(ACT_POP, '0, '0);
        send_word(ACT_INSERT, 64'haaaa_5555_aaaa_5555, 10'h2aa);
        send_word(ACT_POP, '0, '0);

        // ---- random part, in bursts of one flavor each ----
        while (sent < RANDOM_WORDS)
        begin
            mode      = $urandom_range(MODE_FILL, MODE_MIXED);
            burst_len = (mode == MODE_FILL) ? $urandom_range(60, 120) : $urandom_range(20, 80);
            ins_pct   = (mode == MODE_FILL) ? 90 : (mode == MODE_DRAIN) ? 15 : 55;
            for (int i = 0; i < burst_len && sent < RANDOM_WORDS; i++)
            begin
                // one long backpressure episode, and a stretch with no idling
                if (sent == 300)
                begin
                    hold_req = 1'b1;
                end
                idle_en = !(sent >= 700 && sent < 1000);

                roll = $urandom_range(0, 99);
                if (roll < 1)
                begin
                    act = ACT_UNUSED;
                end
                else if (mode != MODE_FILL && roll < 3)
                begin
                    act = ACT_FLUSH;   // no flush in fill bursts, so full gets reached
                end
                else if ($urandom_range(0, 99) < ins_pct)
                begin
                    act = ACT_INSERT;
                end
                else
                begin
                    act = ACT_POP;
                end
                // payload is random for every code; only inserts use it
                send_word(act, pick_stamp(), SYN_W'($urandom_range(0, 1023)));
                sent++;
            end
        end
        cmd_valid <= 1'b0;
        idle_en = 1'b1;

        // ---- drain and verdict ----
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("tb_sorted_event_time_queue: done, clean");
        end
        else
        begin
            $display("tb_sorted_event_time_queue: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/setq_pkg.sv
rtl/setq_cell.sv
rtl/setq_skid.sv
rtl/sorted_event_time_queue.sv
sim/setq_checker.sv
sim/tb_sorted_event_time_queue.sv
